// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for the concurrent checks in the histogram RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is high.
`define LBH_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// Check that also holds across reset.
`define LBH_ASSERT_NR(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) \
    else $error(msg);

`endif

// ===== rtl/lbh_pkg.sv =====
// ----------------------------------------------------------------------------
// lbh_pkg
// Types, constants and helper functions of the log2 latency histogram.
// ----------------------------------------------------------------------------
package lbh_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int CNT_W       = 48;
  localparam int NS_W        = 48;
  localparam int SUM_W       = 64;
  localparam int BP_W        = 14;
  localparam int PCT_W       = 16;
  localparam int Y_W         = CNT_W + BP_W;
  localparam int CUM_W       = Y_W + BKT_W + 1;

  localparam logic [Y_W-1:0] SCALE = Y_W'(10000);
  localparam logic [Y_W-1:0] ROUND = Y_W'(5000);

  localparam int             FB_W      = 26;
  localparam int             RECIP_W   = 27;
  localparam int             RECIP_SH  = 36;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(68719477);
  localparam logic [NS_W-1:0] FB_SAT_NS = NS_W'(65536000);

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [BKT_W-1:0] bucket;
    logic [CUM_W-1:0] cum;
  } walk_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [NS_W-1:0]  smallest;
    logic [NS_W-1:0]  largest;
  } stats_t;

  // A sample lands in bucket idx when its microsecond value has bit length idx,
  // with the last bucket taking everything longer.
  function automatic logic in_bucket(input logic [NS_W-1:0] ns,
                                     input logic [BKT_W-1:0] idx);
    logic [63:0] lo;
    logic [63:0] hi;
    logic        above;
    logic        below;
    lo    = (idx == '0) ? 64'd0 : (64'd1000 << (idx - 1'b1));
    hi    = 64'd1000 << idx;
    above = 64'(ns) >= lo;
    below = (int'(idx) == NUM_BUCKETS - 1) || (64'(ns) < hi);
    return above && below;
  endfunction

  function automatic logic [PCT_W-1:0] pct_of(input logic [BKT_W-1:0] bucket);
    logic [PCT_W-1:0] res;
    if (int'(bucket) >= PCT_W) begin
      res = '1;
    end else begin
      res = PCT_W'(1) << bucket;
    end
    return res;
  endfunction

endpackage

// ===== rtl/lbh_cell.sv =====
// ----------------------------------------------------------------------------
// lbh_cell
// One histogram bucket: holds its count and a count scaled by 10000, and
// adds the scaled count to the percentile walk that passes through it.
// ----------------------------------------------------------------------------
module lbh_cell import lbh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [BKT_W-1:0] idx,
  input  logic             record,
  input  logic             clear,
  input  logic [NS_W-1:0]  ns,
  input  logic [Y_W-1:0]   target_y,
  input  walk_t            walk_in,
  output walk_t            walk_out
);

  logic [CNT_W-1:0] count;
  logic [Y_W-1:0]   scaled;
  logic [CUM_W-1:0] cum_sum;
  logic             hit;
  logic             walk_valid;
  logic             walk_found;
  logic [BKT_W-1:0] walk_bucket;
  logic [CUM_W-1:0] walk_cum;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count  <= '0;
      scaled <= '0;
    end else if (record && in_bucket(ns, idx)) begin
      count  <= count + 1'b1;
      scaled <= (&count) ? '0 : scaled + SCALE;
    end
  end

  assign cum_sum = walk_in.cum + CUM_W'(scaled);
  assign hit     = CUM_W'(target_y) < cum_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_valid <= 1'b0;
    end else begin
      walk_valid <= walk_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    walk_found  <= walk_in.found | hit;
    walk_bucket <= walk_in.found ? walk_in.bucket : idx;
    walk_cum    <= cum_sum;
  end

  assign walk_out = '{valid: walk_valid, found: walk_found,
                      bucket: walk_bucket, cum: walk_cum};

endmodule

// ===== rtl/lbh_stats.sv =====
// ----------------------------------------------------------------------------
// lbh_stats
// Running totals of the histogram: sample count, sum, minimum and maximum.
// ----------------------------------------------------------------------------
module lbh_stats import lbh_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            record,
  input  logic            clear,
  input  logic [NS_W-1:0] ns,
  output stats_t          st
);

  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [NS_W-1:0]  smallest;
  logic [NS_W-1:0]  largest;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count    <= '0;
      sum      <= '0;
      smallest <= '1;
      largest  <= '0;
    end else if (record) begin
      count <= count + 1'b1;
      sum   <= sum + SUM_W'(ns);
      if (ns < smallest) begin
        smallest <= ns;
      end
      if (ns > largest) begin
        largest <= ns;
      end
    end
  end

  assign st = '{count: count, sum: sum, smallest: smallest, largest: largest};

endmodule

// ===== rtl/log2_latency_histogram_core.sv =====
// ----------------------------------------------------------------------------
// log2_latency_histogram_core
// Log2 bucket latency histogram with a percentile query.
//
// One input channel (cmd_valid/cmd_ready) carries command, sample_ns and
// percentile_bp. One output channel (res_valid/res_ready) returns one beat
// per input beat with the statistics as they stand after that command.
// The block handles one command at a time. Record, clear and unused
// commands, and a query on an empty histogram, pass from acceptance through
// the finish state to the result register; no new command is taken before
// that. A query on a non-empty histogram passes the launch state, walks the
// row of bucket cells, one cell per cycle, and then the finish state.
// The result waits in an output register, so the next command is accepted
// while a result is still stalled; that command then holds until the
// receiver takes the earlier beat. Reset empties the histogram at once and
// drops any beat in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module log2_latency_histogram_core import lbh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [1:0]        command,
  input  logic [NS_W-1:0]   sample_ns,
  input  logic [BP_W-1:0]   percentile_bp,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [PCT_W-1:0]  percentile_us,
  output logic [CNT_W-1:0]  sample_count,
  output logic [NS_W-1:0]   min_ns,
  output logic [NS_W-1:0]   max_ns,
  output logic [SUM_W-1:0]  sum_ns,
  output logic              is_empty
);

  state_t              state;
  state_t              state_next;
  logic                accept;
  logic                is_rec;
  logic                is_qry;
  logic                is_clr;
  logic                out_free;
  stats_t              st;
  walk_t               chain [NUM_BUCKETS+1];
  logic [Y_W-1:0]      target_y;
  logic [Y_W-1:0]      target_y_next;
  logic [FB_W+RECIP_W-1:0] fb_prod;
  logic [PCT_W-1:0]    fb_us;
  logic [PCT_W-1:0]    pct_reg;

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign out_free  = !res_valid || res_ready;

  always_comb begin
    is_rec = 1'b0;
    is_qry = 1'b0;
    is_clr = 1'b0;
    case (cmd_t'(command))
      CMD_RECORD: is_rec = 1'b1;
      CMD_QUERY:  is_qry = 1'b1;
      CMD_CLEAR:  is_clr = 1'b1;
      default: ;
    endcase
  end

  lbh_stats u_stats (
    .clk    (clk),
    .rst    (rst),
    .record (accept && is_rec),
    .clear  (accept && is_clr),
    .ns     (sample_ns),
    .st     (st)
  );

  assign chain[0] = '{valid: (state == ST_LAUNCH), found: 1'b0,
                      bucket: '0, cum: CUM_W'(SCALE)};

  for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
    lbh_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (BKT_W'(i)),
      .record   (accept && is_rec),
      .clear    (accept && is_clr),
      .ns       (sample_ns),
      .target_y (target_y),
      .walk_in  (chain[i]),
      .walk_out (chain[i+1])
    );
  end

  assign target_y_next = Y_W'(st.count) * Y_W'(percentile_bp) + ROUND;
  assign fb_prod = FB_W'(st.largest) * (FB_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (accept) begin
      target_y <= target_y_next;
    end
    if (state == ST_LAUNCH) begin
      fb_us <= (st.largest >= FB_SAT_NS) ? '1 : PCT_W'(fb_prod >> RECIP_SH);
    end
    if (accept) begin
      pct_reg <= '0;
    end else if (state == ST_WALK && chain[NUM_BUCKETS].valid) begin
      pct_reg <= chain[NUM_BUCKETS].found ? pct_of(chain[NUM_BUCKETS].bucket)
                                          : fb_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (is_qry && st.count != '0) ? ST_LAUNCH : ST_FINISH;
        end
      end
      ST_LAUNCH: state_next = ST_WALK;
      ST_WALK: begin
        if (chain[NUM_BUCKETS].valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      percentile_us <= pct_reg;
      sample_count  <= st.count;
      min_ns        <= st.smallest;
      max_ns        <= st.largest;
      sum_ns        <= st.sum;
      is_empty      <= (st.count == '0);
    end
  end

  `LBH_ASSERT(a_walk_in_walk, clk, rst, chain[NUM_BUCKETS].valid |-> state == ST_WALK, "walk token left the cell row outside the walk state")
  `LBH_ASSERT(a_query_launch, clk, rst, accept && is_qry && st.count != '0 |=> state == ST_LAUNCH, "query on a non-empty histogram did not launch a walk")
  `LBH_ASSERT(a_empty_flag, clk, rst, res_valid |-> is_empty == (sample_count == '0), "empty flag disagrees with the sample count")
  `LBH_ASSERT(a_empty_pct, clk, rst, res_valid && is_empty |-> percentile_us == '0, "percentile reported for an empty histogram")
  `LBH_ASSERT_NR(a_rst_quiet, clk, rst |=> !res_valid && state == ST_IDLE, "reset left a beat or a command in flight")

endmodule

// ===== tb/sv/histogram_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_checker
// Watches the command and result channels of the latency histogram. Each
// accepted command beat is applied to a private copy of the histogram, and
// the statistics it leaves behind are queued. Each accepted result beat is
// compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module histogram_checker import lbh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic             cmd_ready,
  input  logic [1:0]       command,
  input  logic [NS_W-1:0]  sample_ns,
  input  logic [BP_W-1:0]  percentile_bp,
  input  logic             res_valid,
  input  logic             res_ready,
  input  logic [PCT_W-1:0] percentile_us,
  input  logic [CNT_W-1:0] sample_count,
  input  logic [NS_W-1:0]  min_ns,
  input  logic [NS_W-1:0]  max_ns,
  input  logic [SUM_W-1:0] sum_ns,
  input  logic             is_empty,
  output int               mismatches,
  output int               stats_due_depth
);

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [CNT_W-1:0] count;
    logic [NS_W-1:0]  low;
    logic [NS_W-1:0]  high;
    logic [SUM_W-1:0] sum;
    logic             empty;
  } stats_beat_t;

  logic [CNT_W-1:0] bin_count [NUM_BUCKETS];
  logic [CNT_W-1:0] total;
  logic [SUM_W-1:0] ns_sum;
  logic [NS_W-1:0]  low_ns;
  logic [NS_W-1:0]  high_ns;
  stats_beat_t      stats_due [$];
  int               fail_count = 0;

  assign mismatches = fail_count;

  task automatic clear_histogram();
    int b;
    for (b = 0; b < NUM_BUCKETS; b++) begin
      bin_count[b] = '0;
    end
    total   = '0;
    ns_sum  = '0;
    low_ns  = '1;
    high_ns = '0;
  endtask

  function automatic int bucket_for(input logic [NS_W-1:0] ns);
    logic [NS_W-1:0] us;
    int              len;
    us  = ns / NS_W'(1000);
    len = 0;
    while (us != '0) begin
      len++;
      us = us >> 1;
    end
    if (len >= NUM_BUCKETS) begin
      len = NUM_BUCKETS - 1;
    end
    return len;
  endfunction

  function automatic logic [PCT_W-1:0] percentile_for(input logic [BP_W-1:0] bp);
    logic [63:0]      target;
    logic [63:0]      cum;
    logic [63:0]      high_us;
    logic [PCT_W-1:0] answer;
    int               b;
    if (total == '0) begin
      return '0;
    end
    target = (64'(total) * 64'(bp) + 64'(ROUND)) / 64'(SCALE);
    cum    = '0;
    for (b = 0; b < NUM_BUCKETS; b++) begin
      cum = cum + 64'(bin_count[b]);
      if (cum >= target) begin
        if (b >= PCT_W) begin
          answer = '1;
        end else begin
          answer = PCT_W'(1) << b;
        end
        return answer;
      end
    end
    high_us = 64'(high_ns) / 64'd1000;
    if (high_us > 64'((1 << PCT_W) - 1)) begin
      answer = '1;
    end else begin
      answer = PCT_W'(high_us);
    end
    return answer;
  endfunction

  task automatic apply_command(input logic [1:0] cmd, input logic [NS_W-1:0] ns,
                               input logic [BP_W-1:0] bp, output stats_beat_t beat);
    int bin;
    beat.pct = '0;
    case (cmd)
      CMD_RECORD: begin
        bin            = bucket_for(ns);
        total          = total + 1'b1;
        ns_sum         = ns_sum + SUM_W'(ns);
        if (ns < low_ns) low_ns = ns;
        if (ns > high_ns) high_ns = ns;
        bin_count[bin] = bin_count[bin] + 1'b1;
      end
      CMD_QUERY: begin
        beat.pct = percentile_for(bp);
      end
      CMD_CLEAR: begin
        clear_histogram();
      end
      default: begin
      end
    endcase
    beat.count = total;
    beat.low   = low_ns;
    beat.high  = high_ns;
    beat.sum   = ns_sum;
    beat.empty = (total == '0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stats_beat_t want;
    stats_beat_t fresh;
    if (rst) begin
      clear_histogram();
      stats_due.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (stats_due.size() == 0) begin
          $error("result beat arrived with no command outstanding");
          fail_count++;
        end else begin
          want = stats_due.pop_front();
          check_field("percentile_us", 64'(want.pct), 64'(percentile_us));
          check_field("sample_count", 64'(want.count), 64'(sample_count));
          check_field("min_ns", 64'(want.low), 64'(min_ns));
          check_field("max_ns", 64'(want.high), 64'(max_ns));
          check_field("sum_ns", want.sum, sum_ns);
          check_field("is_empty", 64'(want.empty), 64'(is_empty));
        end
      end
      if (cmd_valid && cmd_ready) begin
        apply_command(command, sample_ns, percentile_bp, fresh);
        stats_due.push_back(fresh);
      end
    end
    stats_due_depth <= stats_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the log2 latency histogram: a directed set of edge
// cases, a short run of maximal samples in the saturating bucket, then random
// commands under several idle and stall mixes. The checker predicts and
// compares each beat.
// ----------------------------------------------------------------------------
module testbench;
  import lbh_pkg::*;

  localparam logic [1:0]      CMD_UNUSED       = 2'd3;
  localparam logic [NS_W-1:0] NS_ALL_ONES      = '1;
  localparam logic [BP_W-1:0] BP_ALL_ONES      = '1;
  localparam int              MAX_SAMPLE_BEATS = 24;
  localparam int              PHASE_BEATS      = 400;
  localparam int              DRAIN_CYCLES     = NUM_BUCKETS + 8;

  logic             clk;
  logic             rst;
  logic             cmd_valid;
  logic             cmd_ready;
  logic [1:0]       command;
  logic [NS_W-1:0]  sample_ns;
  logic [BP_W-1:0]  percentile_bp;
  logic             res_valid;
  logic             res_ready;
  logic [PCT_W-1:0] percentile_us;
  logic [CNT_W-1:0] sample_count;
  logic [NS_W-1:0]  min_ns;
  logic [NS_W-1:0]  max_ns;
  logic [SUM_W-1:0] sum_ns;
  logic             is_empty;
  int               mismatches;
  int               stats_due_depth;
  int               idle_pct = 0;
  int               stall_pct = 0;

  log2_latency_histogram_core dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .command(command), .sample_ns(sample_ns), .percentile_bp(percentile_bp),
    .res_valid(res_valid), .res_ready(res_ready),
    .percentile_us(percentile_us), .sample_count(sample_count),
    .min_ns(min_ns), .max_ns(max_ns), .sum_ns(sum_ns), .is_empty(is_empty)
  );

  histogram_checker histogram_check (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .command(command), .sample_ns(sample_ns), .percentile_bp(percentile_bp),
    .res_valid(res_valid), .res_ready(res_ready),
    .percentile_us(percentile_us), .sample_count(sample_count),
    .min_ns(min_ns), .max_ns(max_ns), .sum_ns(sum_ns), .is_empty(is_empty),
    .mismatches(mismatches), .stats_due_depth(stats_due_depth)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [NS_W-1:0] ns,
                           input logic [BP_W-1:0] bp);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid     <= 1'b1;
    command       <= cmd;
    sample_ns     <= ns;
    percentile_bp <= bp;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  task automatic send_random_beat();
    int              pick;
    logic [NS_W-1:0] ns;
    logic [BP_W-1:0] bp;
    pick = $urandom_range(99);
    ns   = NS_W'({$urandom, $urandom});
    if ($urandom_range(3) != 0) begin
      ns = ns >> $urandom_range(NS_W - 1);
    end
    if ($urandom_range(7) == 0) begin
      bp = BP_W'($urandom_range((1 << BP_W) - 1));
    end else begin
      bp = BP_W'($urandom_range(10000));
    end
    if (pick < 58) begin
      send_beat(CMD_RECORD, ns, bp);
    end else if (pick < 93) begin
      send_beat(CMD_QUERY, ns, bp);
    end else if (pick < 96) begin
      send_beat(CMD_CLEAR, ns, bp);
    end else begin
      send_beat(CMD_UNUSED, ns, bp);
    end
  endtask

  initial begin
    int phase;
    int k;
    rst           <= 1'b1;
    cmd_valid     <= 1'b0;
    command       <= CMD_RECORD;
    sample_ns     <= '0;
    percentile_bp <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Edge cases around bucket borders, empty and overrange queries.
    send_beat(CMD_QUERY, '0, BP_W'(5000));
    send_beat(CMD_UNUSED, '0, '0);
    send_beat(CMD_RECORD, NS_W'(0), '0);
    send_beat(CMD_RECORD, NS_W'(999), '0);
    send_beat(CMD_RECORD, NS_W'(1000), '0);
    send_beat(CMD_RECORD, NS_W'(1999), '0);
    send_beat(CMD_RECORD, NS_W'(2000), '0);
    send_beat(CMD_RECORD, NS_W'(16383999), '0);
    send_beat(CMD_RECORD, NS_W'(16384000), '0);
    send_beat(CMD_RECORD, NS_ALL_ONES, '0);
    send_beat(CMD_QUERY, '0, BP_W'(0));
    send_beat(CMD_QUERY, '0, BP_W'(5000));
    send_beat(CMD_QUERY, '0, BP_W'(10000));
    send_beat(CMD_QUERY, '0, BP_ALL_ONES);
    send_beat(CMD_UNUSED, NS_ALL_ONES, BP_ALL_ONES);
    send_beat(CMD_CLEAR, '0, '0);
    send_beat(CMD_QUERY, '0, BP_W'(10000));
    send_beat(CMD_RECORD, NS_W'(5000000), '0);
    send_beat(CMD_QUERY, '0, BP_ALL_ONES);
    send_beat(CMD_QUERY, '0, BP_W'(1));
    send_beat(CMD_CLEAR, NS_ALL_ONES, BP_ALL_ONES);

    // A run of maximal samples, all in the saturating bucket.
    for (k = 0; k < MAX_SAMPLE_BEATS; k++) begin
      send_beat(CMD_RECORD, NS_ALL_ONES, '0);
    end
    send_beat(CMD_QUERY, '0, BP_W'(5000));
    send_beat(CMD_QUERY, '0, BP_ALL_ONES);
    send_beat(CMD_CLEAR, '0, '0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (k = 0; k < PHASE_BEATS; k++) begin
        send_random_beat();
      end
    end
    cmd_valid <= 1'b0;
    @(posedge clk);

    while (stats_due_depth != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && stats_due_depth == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lbh_pkg.sv
rtl/lbh_cell.sv
rtl/lbh_stats.sv
rtl/log2_latency_histogram_core.sv
tb/sv/histogram_checker.sv
tb/sv/testbench.sv
